>>> hdl/csr_smv_pkg.sv
// ----------------------------------------------------------------------------
// csr_smv_pkg
// Shared types and constants of the sparse matrix times dense vector core.
// ----------------------------------------------------------------------------
package csr_smv_pkg;

   // vector store geometry
   localparam int VEC_DEPTH = 1024;
   localparam int VEC_AW    = $clog2(VEC_DEPTH);

   // field widths
   localparam int IDX_W  = 10;
   localparam int LEN_W  = 11;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = 64;
   localparam int FRAC_W = 16;

   // effective length after reset: min(1024, store depth)
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'((VEC_DEPTH < 1024) ? VEC_DEPTH : 1024);

   // input item actions
   typedef enum logic [1:0] {
      ACT_LOAD      = 2'd0,
      ACT_NONZERO   = 2'd1,
      ACT_EMPTY_ROW = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   // control of one term entering the accumulate stage
   typedef struct packed {
      logic valid;
      logic close;
      logic add;
      logic bad;
   } term_ctrl_type;

endpackage

>>> hdl/csr_sparse_matvec_core.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_core
// Streaming CSR sparse matrix times dense vector product in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes vector_length (always ready); write it only while idle.
//   req_* takes one item per cycle: action 0 loads vector element index,
//   action 1 is a nonzero (value, column) with row_end marking the row's last
//   term, action 2 closes an empty row, action 3 is ignored.
//   rsp_* gives one row sum per closed row with its row number, overflow
//   (saturated to 32 bits) and bad_column (some column >= length).
// Timing:
//   one item per cycle sustained while the result register is not blocked. A
//   closing item's result shows on rsp_valid after the vector store read at
//   acceptance, the multiply, then the accumulate into the result register.
//   The feedback loop is the 64-bit saturating accumulate add.
// Reset:
//   clears the accumulator, row number and flags, sets the length to 1024.
//   The vector store is not cleared; load every element before it is used.
// Stall:
//   a blocked result register holds only a closing term; other terms keep
//   flowing, and req_ready falls once the pipeline behind it is full.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_core
   import csr_smv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEN_W-1:0]         csr_vector_length,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [IDX_W-1:0]         req_index,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_row_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_row_sum,
   output logic [IDX_W-1:0]         rsp_row_number,
   output logic                     rsp_overflow,
   output logic                     rsp_bad_column
);

   logic [LEN_W-1:0]         eff_len_ff, eff_len_in;

   action_type               act;
   logic                     accept;
   logic                     col_bad;
   logic                     store_wr;
   logic                     enters;

   // stage 1: vector element read
   logic                     s1_valid_ff;
   logic                     s1_close_ff, s1_add_ff, s1_bad_ff;
   logic signed [DATA_W-1:0] s1_value_ff;
   logic [DATA_W-1:0]        elem;

   // stage 2: product
   logic                     s2_valid_ff;
   logic                     s2_close_ff, s2_add_ff, s2_bad_ff;
   logic signed [PROD_W-1:0] s2_prod_ff, s2_prod_in;

   term_ctrl_type            term_ctrl;
   logic                     term_taken;
   logic                     s2_free, s1_free;

   // effective length is min(register, store depth)
   assign csr_ready  = 1'b1;
   assign eff_len_in = (32'(csr_vector_length) < 32'(VEC_DEPTH)) ?
                       csr_vector_length : LEN_W'(VEC_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         eff_len_ff <= eff_len_in;
      end
   end

   // handshake chain back from the accumulator
   assign s2_free   = !s2_valid_ff || term_taken;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // decode of the accepted item
   always_comb begin
      act      = action_type'(req_action);
      col_bad  = ({1'b0, req_index} >= eff_len_ff);
      store_wr = 1'b0;
      enters   = 1'b0;
      case (act)
         ACT_LOAD: begin
            store_wr = accept && (32'(req_index) < 32'(VEC_DEPTH));
         end
         ACT_NONZERO: begin
            enters = accept;
         end
         ACT_EMPTY_ROW: begin
            enters = accept;
         end
         ACT_NONE: begin
            enters = 1'b0;
         end
         default: begin
            enters = 1'b0;
         end
      endcase
   end

   // vector store: loads write and nonzeros read at acceptance, so a read
   // always sees every earlier load and the read data holds while stalled
   csr_smv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VEC_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (VEC_AW'(req_index)),
      .wr_data (req_value),
      .rd_en   (accept),
      .rd_addr (VEC_AW'(req_index)),
      .rd_data (elem)
   );

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= enters;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_close_ff <= (act == ACT_EMPTY_ROW) || req_row_end;
         s1_add_ff   <= (act == ACT_NONZERO) && !col_bad;
         s1_bad_ff   <= (act == ACT_NONZERO) && col_bad;
         s1_value_ff <= req_value;
      end
   end

   // stage 2 register: full Q32.32 product
   assign s2_prod_in = s1_value_ff * $signed(elem);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_close_ff <= s1_close_ff;
         s2_add_ff   <= s1_add_ff;
         s2_bad_ff   <= s1_bad_ff;
         s2_prod_ff  <= s2_prod_in;
      end
   end

   assign term_ctrl.valid = s2_valid_ff;
   assign term_ctrl.close = s2_close_ff;
   assign term_ctrl.add   = s2_add_ff;
   assign term_ctrl.bad   = s2_bad_ff;

   // accumulate and result register
   csr_smv_mac u_mac (
      .clock          (clock),
      .reset          (reset),
      .term_ctrl      (term_ctrl),
      .term_product   (s2_prod_ff),
      .eff_len        (eff_len_ff),
      .term_taken     (term_taken),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_row_number (rsp_row_number),
      .rsp_overflow   (rsp_overflow),
      .rsp_bad_column (rsp_bad_column)
   );

   // loads and ignored actions never enter the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (accept && (act == ACT_LOAD || act == ACT_NONE)) |=> !s1_valid_ff)
      else $error("non-row item entered the pipeline");

   // a stage 1 item not moving on keeps the input blocked
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !term_taken) |-> !req_ready)
      else $error("item accepted over a stalled stage");

   // the effective length never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      32'(eff_len_ff) <= 32'(VEC_DEPTH))
      else $error("effective length beyond store depth");

endmodule

>>> hdl/csr_smv_ram.sv
// ----------------------------------------------------------------------------
// csr_smv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csr_smv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/csr_smv_mac.sv
// ----------------------------------------------------------------------------
// csr_smv_mac
// Row accumulator: scales each product to Q48.16, adds it with 64-bit
// saturation, closes rows into the result register and steps the row number.
// ----------------------------------------------------------------------------
module csr_smv_mac
   import csr_smv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  term_ctrl_type            term_ctrl,
   input  logic signed [PROD_W-1:0] term_product,
   input  logic [LEN_W-1:0]         eff_len,
   output logic                     term_taken,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_row_sum,
   output logic [IDX_W-1:0]         rsp_row_number,
   output logic                     rsp_overflow,
   output logic                     rsp_bad_column
);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     err_ff, err_in;
   logic [IDX_W-1:0]         row_ff, row_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]         num_ff, num_in;
   logic                     ovf_ff, ovf_in;
   logic                     bad_ff, bad_in;

   logic                     out_free;
   logic                     fire;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W:0]    sum_wide;
   logic signed [ACC_W-1:0]  acc_new;
   logic                     err_new;
   logic                     fits32;
   logic [IDX_W-1:0]         row_inc;

   // a closing term needs the result register free
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fire       = term_ctrl.valid && (!term_ctrl.close || out_free);
   assign term_taken = fire;

   always_comb begin
      // floor shift of the Q32.32 product to Q48.16, zero for skipped columns
      term = term_ctrl.add ? ACC_W'(term_product >>> FRAC_W) : '0;

      // saturating 64-bit add
      sum_wide = {acc_ff[ACC_W-1], acc_ff} + {term[ACC_W-1], term};
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         acc_new = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_new = sum_wide[ACC_W-1:0];
      end
      err_new = err_ff || term_ctrl.bad;

      // clamp to 32 bits: upper bits must all equal the sign of the low word
      fits32 = (acc_new[ACC_W-1:DATA_W-1] == '0) || (acc_new[ACC_W-1:DATA_W-1] == '1);

      // next row number wraps at the effective length
      row_inc = row_ff + 1'b1;

      acc_in       = acc_ff;
      err_in       = err_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sum_in       = sum_ff;
      num_in       = num_ff;
      ovf_in       = ovf_ff;
      bad_in       = bad_ff;

      if (fire) begin
         if (term_ctrl.close) begin
            rsp_valid_in = 1'b1;
            if (fits32) begin
               sum_in = acc_new[DATA_W-1:0];
            end else begin
               sum_in = acc_new[ACC_W-1] ? SUM_MIN : SUM_MAX;
            end
            ovf_in = !fits32;
            bad_in = err_new;
            num_in = row_ff;
            acc_in = '0;
            err_in = 1'b0;
            row_in = ({1'b0, row_inc} >= eff_len) ? '0 : row_inc;
         end else begin
            acc_in = acc_new;
            err_in = err_new;
         end
      end
   end

   // row state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      num_ff <= num_in;
      ovf_ff <= ovf_in;
      bad_ff <= bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_sum    = sum_ff;
   assign rsp_row_number = num_ff;
   assign rsp_overflow   = ovf_ff;
   assign rsp_bad_column = bad_ff;

   // a closed row leaves a cleared accumulator and error flag
   assert property (@(posedge clock) disable iff (reset)
      (fire && term_ctrl.close) |=> (acc_ff == '0 && !err_ff))
      else $error("accumulator not cleared after row close");

   // a saturated result carries one of the two limits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ovf_ff) |-> (sum_ff == SUM_MAX || sum_ff == SUM_MIN))
      else $error("overflow flagged on an unsaturated sum");

   // a closing term is never taken while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && term_ctrl.valid && term_ctrl.close) |-> !fire)
      else $error("row closed into a full result register");

endmodule
